// ===== sv/cms_pkg.sv =====
package cms_pkg;

    typedef logic [7:0] t_byte;

    localparam int MARKER_MAX  = 32;
    localparam int OFFSET_BITS = 16;

    localparam t_byte CHAR_NUL   = 8'h00;
    localparam t_byte CHAR_SLASH = 8'h2F;
    localparam t_byte CHAR_STAR  = 8'h2A;

    // 22-byte binding-map marker; bytes past it are zero and never match
    localparam t_byte MARKER_TEXT [MARKER_MAX] = '{
        8'h4E, 8'h47, 8'h46, 8'h5F, 8'h4E, 8'h41, 8'h54, 8'h49,
        8'h56, 8'h45, 8'h5F, 8'h42, 8'h49, 8'h4E, 8'h44, 8'h49,
        8'h4E, 8'h47, 8'h5F, 8'h4D, 8'h41, 8'h50, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // data: window byte held by a cell
    // flag: this byte and all younger ones match the head of the marker
    typedef struct packed {
        logic  flag;
        t_byte data;
    } t_cell_link;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] offset;
        logic                   overflow;
    } t_result;

    function automatic t_byte marker_byte(input int idx);
        t_byte b;
        b = CHAR_NUL;
        if (idx >= 0 && idx < MARKER_MAX) begin
            b = MARKER_TEXT[idx];
        end
        return b;
    endfunction

endpackage

// ===== sv/cms_if.sv =====
interface cms_char_if;
    import cms_pkg::*;

    logic  valid;
    logic  ready;
    t_byte char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface cms_result_if;
    import cms_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [OFFSET_BITS-1:0] offset;
    logic                   overflow;

    modport source (output valid, output found, output offset, output overflow, input ready);
    modport sink   (input valid, input found, input offset, input overflow, output ready);
endinterface

// ===== sv/comment_marker_scanner_unit.sv =====
// Output: each result word is registered in the output buffer before it leaves.
// Throughput: one text byte per cycle; the window is a chain of byte cells that all shift
//   together and carry a running match flag, so the marker compare never takes extra cycles.
// Input stalls only when two result words wait at the output (output register plus skid).
// Reset: i_rst_n is synchronous, active low; it empties the window, clears the comment,
//   count, fill and match state and drops any pending result.
module comment_marker_scanner_unit
    import cms_pkg::*;
#(
    parameter int MARKER_LEN    = 22,
    parameter int POSITION_BITS = 16
) (
    input logic              i_clk,
    input logic              i_rst_n,
    cms_char_if.sink         i_char,
    cms_result_if.source     o_result
);

    localparam int FILL_BITS = $clog2(MARKER_LEN + 1);
    localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(MARKER_LEN);
    localparam logic [POSITION_BITS-1:0] COUNT_MAX = {POSITION_BITS{1'b1}};

    // window chain: cell 0 holds the oldest byte, the new byte enters at the top
    t_cell_link w_link [MARKER_LEN+1];
    t_cell_link w_next [MARKER_LEN];
    t_cell_ctrl w_ctrl;

    logic                     r_inside;
    logic                     n_inside;
    logic                     r_matched;
    logic                     n_matched;
    logic                     r_sat;
    logic                     n_sat;
    logic [POSITION_BITS-1:0] r_count;
    logic [POSITION_BITS-1:0] n_count;
    logic [FILL_BITS-1:0]     r_fill;
    logic [FILL_BITS-1:0]     n_fill;

    logic    w_in_ready;
    logic    w_fire;
    logic    w_is_nul;
    logic    w_open;
    logic    w_close;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    assign w_fire   = i_char.valid && w_in_ready;
    assign w_is_nul = (i_char.char_in == CHAR_NUL);

    // advance the window on every counted byte; a zero byte wipes it
    always_comb begin
        w_ctrl.shift = w_fire && !w_is_nul && !r_matched;
        w_ctrl.clear = w_fire && w_is_nul;
    end

    // the top of the chain sees the incoming byte and an always-true match run
    assign w_link[MARKER_LEN].data = i_char.char_in;
    assign w_link[MARKER_LEN].flag = 1'b1;

    for (genvar k = 0; k < MARKER_LEN; k++) begin : g_cell
        cms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_char  (i_char.char_in),
            .i_ref   (marker_byte(MARKER_LEN - 1 - k)),
            .i_link  (w_link[k+1]),
            .o_link  (w_link[k]),
            .o_next  (w_next[k])
        );
    end

    // comment delimiters are judged on the window after this byte is shifted in
    assign w_open  = (w_next[0].data == CHAR_SLASH) && (w_next[1].data == CHAR_STAR);
    assign w_close = (w_next[0].data == CHAR_STAR) && (w_next[1].data == CHAR_SLASH);

    always_comb begin
        n_inside    = r_inside;
        n_matched   = r_matched;
        n_sat       = r_sat;
        n_count     = r_count;
        n_fill      = r_fill;
        w_res_valid = 1'b0;
        w_res       = '0;

        if (w_fire) begin
            if (w_is_nul) begin
                // end of string: report not-found unless a match already went out
                w_res_valid    = !r_matched;
                w_res.overflow = r_sat;
                n_inside       = 1'b0;
                n_matched      = 1'b0;
                n_sat          = 1'b0;
                n_count        = '0;
                n_fill         = '0;
            end else if (!r_matched) begin
                // hold the counter at its top and flag the overflow
                if (r_count == COUNT_MAX) begin
                    n_sat = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
                if (r_fill != FILL_FULL) begin
                    n_fill = r_fill + 1'b1;
                end
                if (n_fill == FILL_FULL) begin
                    if (!r_inside) begin
                        n_inside = w_open;
                    end else if (w_close) begin
                        n_inside = 1'b0;
                    end else if (w_next[0].flag) begin
                        n_matched      = 1'b1;
                        w_res_valid    = 1'b1;
                        w_res.found    = 1'b1;
                        w_res.offset   = OFFSET_BITS'(n_count);
                        w_res.overflow = n_sat;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside  <= 1'b0;
            r_matched <= 1'b0;
            r_sat     <= 1'b0;
            r_count   <= '0;
            r_fill    <= '0;
        end else begin
            r_inside  <= n_inside;
            r_matched <= n_matched;
            r_sat     <= n_sat;
            r_count   <= n_count;
            r_fill    <= n_fill;
        end
    end

    cms_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_res_valid),
        .i_result (w_res),
        .o_ready  (w_in_ready),
        .o_valid  (o_result.valid),
        .o_result (w_out),
        .i_ready  (o_result.ready)
    );

    assign i_char.ready      = w_in_ready;
    assign o_result.found    = w_out.found;
    assign o_result.offset   = w_out.offset;
    assign o_result.overflow = w_out.overflow;

endmodule

// ===== sv/cms_cell.sv =====
module cms_cell
    import cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_byte      i_char,
    input  t_byte      i_ref,
    input  t_cell_link i_link,
    output t_cell_link o_link,
    output t_cell_link o_next
);

    t_cell_link r_link;
    t_cell_link n_link;
    t_cell_link w_shifted;

    // take the neighbor's byte; extend its match run if the new word fits here
    always_comb begin
        w_shifted.data = i_link.data;
        w_shifted.flag = i_link.flag && (i_char == i_ref);
    end

    always_comb begin
        n_link = r_link;
        if (i_ctrl.clear) begin
            n_link = '0;
        end else if (i_ctrl.shift) begin
            n_link = w_shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;
    assign o_next = w_shifted;

endmodule

// ===== sv/cms_out_buf.sv =====
module cms_out_buf
    import cms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid;
    t_result n_skid;
    logic    w_take;

    assign w_take = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out       = i_result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_result;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== sv/cms_checker.sv =====
module cms_checker
    import cms_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_found,
    input logic [OFFSET_BITS-1:0] i_offset,
    input logic                   i_overflow
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_found) && $stable(i_offset) && $stable(i_overflow))
        else $error("stalled result word changed");

    // with no result pending the scanner must take input
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // a not-found word carries a zero offset
    a_miss_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_offset == '0)
        else $error("not-found word with nonzero offset");

    // a result right after reset needs an accepted byte first
    a_no_spurious: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word out of reset");

endmodule

bind comment_marker_scanner_unit cms_checker u_cms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_char.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_found     (o_result.found),
    .i_offset    (o_result.offset),
    .i_overflow  (o_result.overflow)
);

// ===== bench/testbench.sv =====
module testbench;
    import cms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Block configuration under test (matches the default parameters)
    localparam int MARKER_LEN    = 22;
    localparam int POSITION_BITS = 16;

    // Stimulus sizing
    localparam int RANDOM_BYTES = 1530;
    localparam int MAX_GAP      = 19;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_CAP    = 100;

    // Predicts the scanner word by word and holds the results still owed by the block
    class marker_scoreboard;
        t_byte                    window [MARKER_LEN];
        bit                       comment_open;
        bit [POSITION_BITS-1:0]   position;
        bit                       matched;
        int                       fill;
        bit                       saturated;
        t_result                  owed [$];
        int                       error_count;
        int                       scanned;

        function new();
            error_count = 0;
            scanned     = 0;
            restart_scan();
        endfunction

        function void restart_scan();
            foreach (window[k]) window[k] = CHAR_NUL;
            comment_open = 1'b0;
            position     = '0;
            matched      = 1'b0;
            fill         = 0;
            saturated    = 1'b0;
        endfunction

        function void note_byte(t_byte c);
            t_result r;
            bit      hit;
            scanned++;
            if (c == CHAR_NUL) begin
                // end of string: report not-found unless a match already went out
                if (!matched) begin
                    r.found    = 1'b0;
                    r.offset   = '0;
                    r.overflow = saturated;
                    owed.push_back(r);
                end
                restart_scan();
                return;
            end
            if (matched) return;
            if (position == '1) saturated = 1'b1;
            else position++;
            for (int k = 0; k < MARKER_LEN - 1; k++) window[k] = window[k + 1];
            window[MARKER_LEN - 1] = c;
            if (fill < MARKER_LEN) fill++;
            if (fill < MARKER_LEN) return;
            if (!comment_open) begin
                if (window[0] == CHAR_SLASH && window[1] == CHAR_STAR) comment_open = 1'b1;
                return;
            end
            if (window[0] == CHAR_STAR && window[1] == CHAR_SLASH) begin
                comment_open = 1'b0;
                return;
            end
            hit = 1'b1;
            for (int k = 0; k < MARKER_LEN; k++) begin
                if (window[k] != MARKER_TEXT[k % MARKER_MAX]) hit = 1'b0;
            end
            if (hit) begin
                matched    = 1'b1;
                r.found    = 1'b1;
                r.offset   = position[OFFSET_BITS-1:0];
                r.overflow = saturated;
                owed.push_back(r);
            end
        endfunction

        function void flag_error();
            error_count++;
        endfunction

        function void check_result(logic found, logic [OFFSET_BITS-1:0] offset,
                                   logic overflow);
            t_result want;
            if (owed.size() == 0) begin
                flag_error();
                if (error_count <= PRINT_CAP)
                    $display("%0t: unexpected result word, expected none, actual %0d/%0d/%0d",
                             $time, found, offset, overflow);
                return;
            end
            want = owed.pop_front();
            if (found !== want.found) begin
                flag_error();
                if (error_count <= PRINT_CAP)
                    $display("%0t: found mismatch, expected %0d, actual %0d",
                             $time, want.found, found);
            end
            if (offset !== want.offset) begin
                flag_error();
                if (error_count <= PRINT_CAP)
                    $display("%0t: offset mismatch, expected %0d, actual %0d",
                             $time, want.offset, offset);
            end
            if (overflow !== want.overflow) begin
                flag_error();
                if (error_count <= PRINT_CAP)
                    $display("%0t: overflow mismatch, expected %0d, actual %0d",
                             $time, want.overflow, overflow);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cms_char_if   char_bus ();
    cms_result_if result_bus ();

    comment_marker_scanner_unit #(
        .MARKER_LEN    (MARKER_LEN),
        .POSITION_BITS (POSITION_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_bus),
        .o_result (result_bus)
    );

    marker_scoreboard sb = new();

    // Text under construction; the sender sends it and appends the zero byte
    t_byte text_buf [$];

    int cycle_count = 0;
    int rx_stall    = 0;
    bit rx_calm     = 1'b0;

    // Drive every input to a known level before the first edge
    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        char_bus.valid    = 1'b0;
        char_bus.char_in  = CHAR_NUL;
        result_bus.ready  = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    // Hard stop: a hung handshake must not run forever
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: after each accepted result word, hold ready low for a drawn number
    // of cycles; now and then switch into a calm stretch where ready stays high.
    always @(posedge i_clk) begin
        if (result_bus.valid && result_bus.ready) begin
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
            rx_stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
        end else if (rx_stall > 0) begin
            rx_stall--;
        end
        result_bus.ready <= (rx_stall == 0);
    end

    // Check every result word accepted at this edge against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready)
            sb.check_result(result_bus.found, result_bus.offset, result_bus.overflow);
    end

    function automatic void append_str(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(t_byte'(s[i]));
    endfunction

    // Append the first len bytes of the marker
    function automatic void append_marker(int len);
        for (int i = 0; i < len; i++) text_buf.push_back(MARKER_TEXT[i]);
    endfunction

    // Filler biased toward the bytes that steer the comment and marker logic
    function automatic void append_noise(int len);
        t_byte b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0:       b = CHAR_SLASH;
                1:       b = CHAR_STAR;
                2:       b = MARKER_TEXT[$urandom_range(0, MARKER_LEN - 1)];
                default: b = t_byte'($urandom_range(1, 255));
            endcase
            text_buf.push_back(b);
        end
    endfunction

    // Marker with one byte replaced by a random nonzero byte
    function automatic void append_near_miss();
        int    spot;
        t_byte b;
        spot = $urandom_range(0, MARKER_LEN - 1);
        for (int i = 0; i < MARKER_LEN; i++) begin
            b = MARKER_TEXT[i];
            if (i == spot) b = t_byte'($urandom_range(1, 255));
            text_buf.push_back(b);
        end
    endfunction

    // Mostly well-formed commented text with random content; a tenth pure noise
    function automatic void build_random_text();
        int segments;
        text_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            append_noise($urandom_range(0, 40));
            return;
        end
        append_noise($urandom_range(0, 6));
        if ($urandom_range(0, 3) != 0) append_str("/*");
        segments = $urandom_range(1, 6);
        for (int s = 0; s < segments; s++) begin
            case ($urandom_range(0, 9))
                0, 1: append_noise($urandom_range(0, 8));
                2:    append_str("/*");
                3:    append_str("*/");
                4, 5: append_marker(MARKER_LEN);
                6:    append_near_miss();
                7:    append_marker($urandom_range(1, MARKER_LEN - 1));
                8:    append_str("/*/");
                default: append_str("/**/");
            endcase
        end
        if ($urandom_range(0, 1) == 0) append_noise($urandom_range(0, 5));
    endfunction

    // Present one byte; keep valid high across back-to-back words
    task automatic send_byte(t_byte b, int gap);
        if (gap > 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_bus.valid   <= 1'b1;
        char_bus.char_in <= b;
        do @(posedge i_clk); while (!char_bus.ready);
        sb.note_byte(b);
    endtask

    // Send the buffered text and its terminating zero; quiet texts go without gaps
    task automatic send_text(bit quiet);
        foreach (text_buf[i])
            send_byte(text_buf[i], quiet ? 0 : $urandom_range(0, MAX_GAP));
        send_byte(CHAR_NUL, quiet ? 0 : $urandom_range(0, MAX_GAP));
    endtask

    // Drop valid and hold the sender until every owed result word has arrived
    task automatic drain_results();
        char_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.owed.size() != 0);
    endtask

    initial begin
        int base;
        bit halfway_done;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty string: the zero byte alone gives not-found
        text_buf.delete();
        send_text(1'b0);

        // Marker right after the comment opener, ending the string
        text_buf.delete();
        append_str("/*");
        append_marker(MARKER_LEN);
        send_text(1'b0);

        // Marker outside any comment
        text_buf.delete();
        append_marker(MARKER_LEN);
        send_text(1'b0);

        // Opener whose star also starts a closer: the comment ends at once
        text_buf.delete();
        append_str("/*/");
        append_marker(MARKER_LEN);
        send_text(1'b0);

        // Empty comment before the marker
        text_buf.delete();
        append_str("/**/");
        append_marker(MARKER_LEN);
        send_text(1'b0);

        // Closed comment, then a new one holding the marker, then ignored tail bytes
        text_buf.delete();
        append_str("/* x */ /* ");
        append_marker(MARKER_LEN);
        append_str(" */ tail /* ");
        append_marker(MARKER_LEN);
        send_text(1'b0);

        // Short string that can never fill the window
        text_buf.delete();
        append_str("/*");
        send_text(1'b0);

        // Byte extremes ahead of a match
        text_buf.delete();
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h01);
        append_str("/*");
        append_marker(MARKER_LEN);
        send_text(1'b0);

        // Truncated marker: the zero byte arrives one byte early
        text_buf.delete();
        append_str("/*");
        append_marker(MARKER_LEN - 1);
        send_text(1'b0);

        // Let every directed result land before the random part
        drain_results();

        base = sb.scanned;
        halfway_done = 1'b0;
        while (sb.scanned - base < RANDOM_BYTES) begin
            build_random_text();
            send_text($urandom_range(0, 3) == 0);
            if (!halfway_done && sb.scanned - base >= RANDOM_BYTES / 2) begin
                halfway_done = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.owed.size() != 0)
            $display("%0t: %0d expected result words never arrived, expected 0, actual %0d",
                     $time, sb.owed.size(), sb.owed.size());
        if (sb.error_count == 0 && sb.owed.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cms_pkg.sv
sv/cms_if.sv
sv/cms_cell.sv
sv/cms_out_buf.sv
sv/comment_marker_scanner_unit.sv
sv/cms_checker.sv
bench/testbench.sv
